>>> rtl/plc_pkg.sv
// plc_pkg: shared types, command codes and helpers for the pi lead controller
// depends on nothing; imported by the top level, datapath and controller files and the testbench
package plc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_GAIN          = 3'd0;
    localparam logic [2:0] REG_LEAD_TIME     = 3'd1;
    localparam logic [2:0] REG_LEAD_RATIO    = 3'd2;
    localparam logic [2:0] REG_INTEGRAL_TIME = 3'd3;
    localparam logic [2:0] REG_FOLD_MODE     = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int WORD_W      = 32;

    // lu0 ceiling, 2^36 raw
    localparam logic signed [65:0] LU0_CAP = 66'sd68719476736;
    // pi scaled by 2^32
    localparam logic signed [63:0] PI_Q32  = 64'sd13493037705;

    // datapath commands
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_HOLD_OUT,
        OP_FOLD_ABS,
        OP_FOLD_MULQ,
        OP_FOLD_MULD,
        OP_FOLD_REM,
        OP_FOLD_FIX,
        OP_MUL_ERR,
        OP_ERR_SAT,
        OP_MUL_LU,
        OP_LU_DEN,
        OP_DIV_COEF,
        OP_COEF_STORE,
        OP_MUL_MAC,
        OP_MAC_ACC,
        OP_LEAD_SAT,
        OP_INT_HOLD,
        OP_DIV_K,
        OP_K_STORE,
        OP_MUL_INT,
        OP_INT_ADD,
        OP_COMMIT
    } plc_op_t;

    typedef struct packed {
        plc_op_t    op;
        logic [1:0] sel;   // coefficient / term index
    } plc_cmd_t;

    typedef struct packed {
        logic dt_zero;
        logic fold_en;
        logic lead_en;
        logic int_en;
        logic div_done;
        logic out_free;
    } plc_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/pi_lead_controller.sv
// pi_lead_controller: top level of the fixed-point pi controller with tustin lead
// depends on plc_pkg, plc_ctrl, plc_datapath (and plc_divider below it)
//
//  channel  | ports                                  | carries
//  ---------+----------------------------------------+------------------------------
//  input    | s_tvalid s_tready s_tdata s_tuser      | one update request
//  result   | m_tvalid m_tready m_tdata              | drive value per request
//  config   | cfg_valid cfg_ready cfg_index cfg_data | register write, always ready
//
// a zero time step goes straight to holding the last drive; otherwise each request
// steps through the angle fold (reciprocal multiply and one correction), the lead
// stage and the integrator when enabled, using the one shared bit-serial divider
// (one quotient bit a cycle) behind a single multiplier.
// reset (aresetn low, synchronous) clears the history, restores register
// defaults and drops m_tvalid. a finished result waits in the output register
// while the next request is taken; only the final commit or hold step waits on m_tready.
module pi_lead_controller import plc_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // fields from bit 0: time_step[30:0], target[62:31], measurement[94:63], zero pad
    input  logic [95:0]            s_tdata,
    // fields from bit 0: actuator_saturated
    input  logic                   s_tuser,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // fields from bit 0: drive[31:0]
    output logic [31:0]            m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data
);

    plc_cmd_t    cmd;
    plc_status_t status;

    // config writes land at once, so the port never stalls
    assign cfg_ready = 1'b1;

    plc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    plc_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .status                (status),
        .cfg_we                (cfg_valid),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .in_time_step          (s_tdata[30:0]),
        .in_target             ($signed(s_tdata[62:31])),
        .in_measurement        ($signed(s_tdata[94:63])),
        .in_actuator_saturated (s_tuser),
        .out_ready             (m_tready),
        .out_valid             (m_tvalid),
        .out_drive             (m_tdata)
    );

endmodule

>>> rtl/plc_divider.sv
// plc_divider: restoring unsigned divider, one quotient bit per cycle
// depends on nothing; plc_pkg is not imported
module plc_divider #(
    parameter int NUM_W = 53,
    parameter int DEN_W = 38
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] qn_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diff;

    assign trial = {rem_reg, qn_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            qn_reg  <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            qn_reg  <= {qn_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = qn_reg;

endmodule

>>> rtl/plc_datapath.sv
// plc_datapath: config registers, loop state, shared multiplier and divider
// depends on plc_pkg and plc_divider
module plc_datapath import plc_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  plc_cmd_t               cmd,
    output plc_status_t            status,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data,
    input  logic [30:0]            in_time_step,
    input  logic signed [31:0]     in_target,
    input  logic signed [31:0]     in_measurement,
    input  logic                   in_actuator_saturated,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [31:0]            out_drive
);

    localparam int F     = FRACTION_BITS;
    localparam int NUM_W = 37 + F;
    localparam int DEN_W = 38;
    localparam logic signed [63:0] PI_Q =
        (PI_Q32 + (64'sd1 <<< (31 - F))) >>> (32 - F);
    localparam logic signed [63:0] TWO_PI = 2 * PI_Q;
    // reciprocal of 2pi for the angle fold; the estimate is low by at most one
    localparam int FOLD_SH = F + 29;
    localparam logic signed [63:0] FOLD_RCP = (64'sd1 <<< FOLD_SH) / TWO_PI;

    // config
    logic signed [31:0] gain_reg;
    logic [30:0]        lead_time_reg;
    logic [30:0]        lead_ratio_reg;
    logic [30:0]        integral_time_reg;
    logic               fold_reg;

    // loop state
    logic signed [31:0] prev_error_reg;
    logic signed [31:0] prev_lead_reg;
    logic signed [31:0] prev_int_reg;

    // per-request working registers
    logic [30:0]        dt_reg;
    logic               sat_flag_reg;
    logic signed [32:0] diff_reg;
    logic signed [31:0] ep_reg;
    logic signed [31:0] up_reg;
    logic signed [31:0] ui_reg;
    logic signed [31:0] k_reg;
    logic signed [31:0] c_reg [3];
    logic signed [65:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic [36:0]        lu0_reg;
    logic [DEN_W-1:0]   den_reg;
    logic               neg_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_reg;

    // divider
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic               div_done;
    logic [NUM_W-1:0]   div_quo;
    logic               neg_next;

    plc_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // shared arithmetic
    logic signed [63:0] dt64;
    logic signed [63:0] le0_64;
    logic signed [63:0] lu0_64;
    logic signed [63:0] xs;
    logic signed [63:0] nsel;
    logic signed [63:0] mag;
    logic signed [63:0] q_mag;
    logic signed [63:0] q_s;
    logic signed [65:0] fold_q;
    logic signed [63:0] rem_f;
    logic signed [32:0] fold_d;
    logic signed [65:0] sh_f;
    logic signed [65:0] sh_f1;
    logic signed [63:0] term;
    logic signed [65:0] lu_c;
    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [31:0] mac_x;
    logic signed [32:0] isum;

    assign dt64   = $signed({33'd0, dt_reg});
    assign le0_64 = $signed({32'd0, lead_time_reg, 1'b0});
    assign lu0_64 = $signed({27'd0, lu0_reg});
    assign xs     = 64'(diff_reg) + PI_Q;
    assign q_mag  = $signed(64'(div_quo));
    assign q_s    = neg_reg ? -q_mag : q_mag;
    assign fold_q = prod_reg >>> FOLD_SH;
    assign rem_f  = (acc_reg >= TWO_PI) ? acc_reg - TWO_PI : acc_reg;
    assign fold_d = neg_reg ? ((rem_f == 64'sd0) ? 33'(-PI_Q) : 33'(PI_Q - rem_f))
                            : 33'(rem_f - PI_Q);
    assign sh_f   = prod_reg >>> F;
    assign sh_f1  = prod_reg >>> (F + 1);
    assign term   = $signed(sh_f[63:0]);
    assign lu_c   = (sh_f > LU0_CAP) ? LU0_CAP : sh_f;
    assign isum   = 33'(up_reg) + 33'(prev_lead_reg);

    always_comb begin
        case (cmd.sel)
            2'd0:    mac_x = ep_reg;
            2'd1:    mac_x = prev_error_reg;
            default: mac_x = prev_lead_reg;
        endcase
    end

    always_comb begin
        case (cmd.sel)
            2'd0:    nsel = dt64 + le0_64;
            2'd1:    nsel = dt64 - le0_64;
            default: nsel = dt64 - lu0_64;
        endcase
    end

    // operand select for the one multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_FOLD_MULQ: begin
                mul_a = acc_reg[33:0];
                mul_b = FOLD_RCP[31:0];
            end
            OP_FOLD_MULD: begin
                mul_a = fold_q[33:0];
                mul_b = TWO_PI[31:0];
            end
            OP_MUL_ERR: begin
                mul_a = 34'(sat32(64'(diff_reg)));
                mul_b = gain_reg;
            end
            OP_MUL_LU: begin
                mul_a = $signed({2'b00, lead_time_reg, 1'b0});
                mul_b = $signed({1'b0, lead_ratio_reg});
            end
            OP_MUL_MAC: begin
                mul_a = 34'(c_reg[cmd.sel]);
                mul_b = mac_x;
            end
            OP_MUL_INT: begin
                mul_a = 34'(isum);
                mul_b = k_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // divider operand select, plus the fold magnitude
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        neg_next  = 1'b0;
        mag       = '0;
        unique case (cmd.op)
            OP_FOLD_ABS: begin
                neg_next  = xs < 64'sd0;
                mag       = neg_next ? -xs : xs;
            end
            OP_DIV_COEF: begin
                div_start = 1'b1;
                neg_next  = nsel < 64'sd0;
                mag       = neg_next ? -nsel : nsel;
                mag       = mag <<< F;
                div_num   = mag[NUM_W-1:0];
                div_den   = den_reg;
            end
            OP_DIV_K: begin
                div_start = 1'b1;
                mag       = dt64 <<< F;
                div_num   = mag[NUM_W-1:0];
                div_den   = DEN_W'(integral_time_reg);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg          <= 32'sd1 <<< F;
            lead_time_reg     <= '0;
            lead_ratio_reg    <= '0;
            integral_time_reg <= '0;
            fold_reg          <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GAIN:          gain_reg          <= $signed(cfg_data);
                REG_LEAD_TIME:     lead_time_reg     <= cfg_data[30:0];
                REG_LEAD_RATIO:    lead_ratio_reg    <= cfg_data[30:0];
                REG_INTEGRAL_TIME: integral_time_reg <= cfg_data[30:0];
                REG_FOLD_MODE:     fold_reg          <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // loop state and output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_error_reg <= '0;
            prev_lead_reg  <= '0;
            prev_int_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.op == OP_COMMIT) begin
                prev_error_reg <= ep_reg;
                prev_lead_reg  <= up_reg;
                prev_int_reg   <= ui_reg;
                out_valid_reg  <= 1'b1;
            end else if (cmd.op == OP_HOLD_OUT) begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (div_start || cmd.op == OP_FOLD_ABS) begin
            neg_reg <= neg_next;
        end
        unique case (cmd.op) inside
            OP_LOAD: begin
                dt_reg       <= in_time_step;
                sat_flag_reg <= in_actuator_saturated;
                diff_reg     <= 33'(in_target) - 33'(in_measurement);
            end
            OP_HOLD_OUT:   out_reg  <= sat32(64'(prev_int_reg) + 64'(prev_lead_reg));
            OP_FOLD_ABS:   acc_reg  <= mag;
            OP_FOLD_REM:   acc_reg  <= acc_reg - $signed(prod_reg[63:0]);
            OP_FOLD_FIX:   diff_reg <= fold_d;
            OP_MUL_ERR, OP_MUL_LU, OP_MUL_MAC, OP_MUL_INT, OP_FOLD_MULQ, OP_FOLD_MULD:
                prod_reg <= mul_p;
            OP_ERR_SAT: begin
                ep_reg <= sat32(term);
                up_reg <= sat32(term);
            end
            OP_LU_DEN: begin
                lu0_reg <= lu_c[36:0];
                den_reg <= DEN_W'(dt_reg) + DEN_W'(lu_c[36:0]);
            end
            OP_COEF_STORE: c_reg[cmd.sel] <= sat32(q_s);
            OP_MAC_ACC: begin
                if (cmd.sel == 2'd0) begin
                    acc_reg <= term;
                end else if (cmd.sel == 2'd2) begin
                    acc_reg <= acc_reg - term;
                end else begin
                    acc_reg <= acc_reg + term;
                end
            end
            OP_LEAD_SAT:   up_reg <= sat32(acc_reg);
            OP_INT_HOLD:   ui_reg <= prev_int_reg;
            OP_K_STORE:    k_reg  <= sat32(q_s);
            OP_INT_ADD:    ui_reg <= sat32($signed(sh_f1[63:0]) + 64'(prev_int_reg));
            OP_COMMIT:     out_reg <= sat32(64'(ui_reg) + 64'(up_reg));
            default: ;
        endcase
    end

    always_comb begin
        status.dt_zero  = dt_reg == 31'd0;
        status.fold_en  = fold_reg;
        status.lead_en  = lead_time_reg != 31'd0;
        status.int_en   = (integral_time_reg != 31'd0) && !sat_flag_reg;
        status.div_done = div_done;
        status.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_drive = out_reg;

endmodule

>>> rtl/plc_ctrl.sv
// plc_ctrl: sequencer that steps the datapath through one controller update
// depends on plc_pkg
module plc_ctrl import plc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  plc_status_t status,
    output plc_cmd_t    cmd
);

    typedef enum logic [22:0] {
        S_IDLE  = 23'h000001,
        S_CHECK = 23'h000002,
        S_FABS  = 23'h000004,
        S_FMULQ = 23'h000008,
        S_FMULD = 23'h000010,
        S_FREM  = 23'h000020,
        S_FFIX  = 23'h000040,
        S_EMUL  = 23'h000080,
        S_ESAT  = 23'h000100,
        S_LMUL  = 23'h000200,
        S_LDEN  = 23'h000400,
        S_CDIV  = 23'h000800,
        S_CWAIT = 23'h001000,
        S_MMUL  = 23'h002000,
        S_MACC  = 23'h004000,
        S_LSAT  = 23'h008000,
        S_ICHK  = 23'h010000,
        S_KDIV  = 23'h020000,
        S_KWAIT = 23'h040000,
        S_IMUL  = 23'h080000,
        S_IADD  = 23'h100000,
        S_FIN   = 23'h200000,
        S_FINH  = 23'h400000
    } plc_state_t;

    plc_state_t state_reg, state_next;
    logic [1:0] sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sel_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = sel_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (status.dt_zero) begin
                    state_next = S_FINH;
                end else if (status.fold_en) begin
                    state_next = S_FABS;
                end else begin
                    state_next = S_EMUL;
                end
            end
            S_FABS: begin
                cmd.op     = OP_FOLD_ABS;
                state_next = S_FMULQ;
            end
            S_FMULQ: begin
                cmd.op     = OP_FOLD_MULQ;
                state_next = S_FMULD;
            end
            S_FMULD: begin
                cmd.op     = OP_FOLD_MULD;
                state_next = S_FREM;
            end
            S_FREM: begin
                cmd.op     = OP_FOLD_REM;
                state_next = S_FFIX;
            end
            S_FFIX: begin
                cmd.op     = OP_FOLD_FIX;
                state_next = S_EMUL;
            end
            S_EMUL: begin
                cmd.op     = OP_MUL_ERR;
                state_next = S_ESAT;
            end
            S_ESAT: begin
                cmd.op     = OP_ERR_SAT;
                state_next = status.lead_en ? S_LMUL : S_ICHK;
            end
            S_LMUL: begin
                cmd.op     = OP_MUL_LU;
                state_next = S_LDEN;
            end
            S_LDEN: begin
                cmd.op     = OP_LU_DEN;
                sel_next   = 2'd0;
                state_next = S_CDIV;
            end
            S_CDIV: begin
                cmd.op     = OP_DIV_COEF;
                state_next = S_CWAIT;
            end
            S_CWAIT: begin
                if (status.div_done) begin
                    cmd.op = OP_COEF_STORE;
                    if (sel_reg == 2'd2) begin
                        sel_next   = 2'd0;
                        state_next = S_MMUL;
                    end else begin
                        sel_next   = sel_reg + 2'd1;
                        state_next = S_CDIV;
                    end
                end
            end
            S_MMUL: begin
                cmd.op     = OP_MUL_MAC;
                state_next = S_MACC;
            end
            S_MACC: begin
                cmd.op = OP_MAC_ACC;
                if (sel_reg == 2'd2) begin
                    sel_next   = 2'd0;
                    state_next = S_LSAT;
                end else begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_MMUL;
                end
            end
            S_LSAT: begin
                cmd.op     = OP_LEAD_SAT;
                state_next = S_ICHK;
            end
            S_ICHK: begin
                if (status.int_en) begin
                    state_next = S_KDIV;
                end else begin
                    cmd.op     = OP_INT_HOLD;
                    state_next = S_FIN;
                end
            end
            S_KDIV: begin
                cmd.op     = OP_DIV_K;
                state_next = S_KWAIT;
            end
            S_KWAIT: begin
                if (status.div_done) begin
                    cmd.op     = OP_K_STORE;
                    state_next = S_IMUL;
                end
            end
            S_IMUL: begin
                cmd.op     = OP_MUL_INT;
                state_next = S_IADD;
            end
            S_IADD: begin
                cmd.op     = OP_INT_ADD;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (status.out_free) begin
                    cmd.op     = OP_COMMIT;
                    state_next = S_IDLE;
                end
            end
            S_FINH: begin
                if (status.out_free) begin
                    cmd.op     = OP_HOLD_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = state_reg == S_IDLE;

endmodule

>>> rtl/plc_checker.sv
// plc_checker: port-level assertions for pi_lead_controller, bound to the top
// depends on the top level's port list only
module plc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] m_tdata,
    input logic        m_tvalid,
    input logic        m_tready
);

    // held result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // reset drops the result channel
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one request at a time: input closes after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while busy");

    // a new result only appears from a busy block
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without request in progress");

endmodule

bind pi_lead_controller plc_checker u_plc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

>>> tb/pi_lead_controller_check.sv
// pi_lead_controller_check: watches the request, config and result channels, predicts each drive value
// depends on plc_pkg for register indexes; instantiated by pi_lead_controller_test
module pi_lead_controller_check import plc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [95:0] s_tdata,
    input  logic        s_tuser,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          drives_pending
);
    localparam int FB = 16;
    localparam longint LU0_LIMIT = 64'sd68719476736;

    longint cur_gain, cur_lead_time, cur_lead_ratio, cur_int_time, cur_fold;
    longint last_err, last_lead, last_int;
    logic [31:0] drive_queue[$];

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // arithmetic shift rounding toward minus infinity
    function automatic longint shr_floor(input longint p, input int s);
        return p >>> s;
    endfunction

    function automatic logic [31:0] predict_drive(input logic [95:0] req, input logic frozen);
        longint dt, diff, pi_q, m, scaled, lead, integ, le0, lu0, den, c1, c2, c3, k;
        dt = longint'(req[30:0]);
        diff = longint'($signed(req[62:31])) - longint'($signed(req[94:63]));
        if (dt == 0) return 32'(clip32(last_int + last_lead));
        if (cur_fold != 0) begin
            pi_q = (64'sd13493037705 + (64'sd1 << (31 - FB))) >>> (32 - FB);
            m = (diff + pi_q) % (2 * pi_q);
            if (m < 0) m += 2 * pi_q;
            diff = m - pi_q;
        end
        scaled = clip32(shr_floor(cur_gain * clip32(diff), FB));
        if (cur_lead_time != 0) begin
            le0 = 2 * cur_lead_time;
            lu0 = shr_floor(le0 * cur_lead_ratio, FB);
            if (lu0 > LU0_LIMIT) lu0 = LU0_LIMIT;
            den = dt + lu0;
            c1 = clip32(((dt + le0) <<< FB) / den);
            c2 = clip32(((dt - le0) <<< FB) / den);
            c3 = clip32(((dt - lu0) <<< FB) / den);
            lead = clip32(shr_floor(c1 * scaled, FB) + shr_floor(c2 * last_err, FB)
                          - shr_floor(c3 * last_lead, FB));
        end else begin
            lead = scaled;
        end
        if (cur_int_time != 0 && !frozen) begin
            k = clip32((dt <<< FB) / cur_int_time);
            integ = clip32(shr_floor((lead + last_lead) * k, FB + 1) + last_int);
        end else begin
            integ = last_int;
        end
        last_err = scaled;
        last_lead = lead;
        last_int = integ;
        return 32'(clip32(integ + lead));
    endfunction

    assign drives_pending = drive_queue.size();

    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            cur_gain <= 64'sd65536;
            cur_lead_time <= 0;
            cur_lead_ratio <= 0;
            cur_int_time <= 0;
            cur_fold <= 0;
            last_err = 0;
            last_lead = 0;
            last_int = 0;
            drive_queue.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_GAIN:          cur_gain <= longint'($signed(cfg_data));
                    REG_LEAD_TIME:     cur_lead_time <= longint'(cfg_data[30:0]);
                    REG_LEAD_RATIO:    cur_lead_ratio <= longint'(cfg_data[30:0]);
                    REG_INTEGRAL_TIME: cur_int_time <= longint'(cfg_data[30:0]);
                    REG_FOLD_MODE:     cur_fold <= longint'(cfg_data[0]);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) drive_queue.push_back(predict_drive(s_tdata, s_tuser));
            if (m_tvalid && m_tready) begin
                if (drive_queue.size() == 0) begin
                    $error("unexpected drive result %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = drive_queue.pop_front();
                    if (want !== m_tdata) begin
                        $error("field drive: expected %h actual %h", want, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> tb/pi_lead_controller_test.sv
// pi_lead_controller_test: drives requests, register writes and result stalls into the controller
// depends on plc_pkg, pi_lead_controller and pi_lead_controller_check
module pi_lead_controller_test import plc_pkg::*;;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    // fields from bit 0: time_step[30:0], target[62:31], measurement[94:63], zero pad
    logic [95:0] s_tdata = '0;
    // fields from bit 0: actuator_saturated
    logic        s_tuser = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // fields from bit 0: drive[31:0]
    logic [31:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          fail_count;
    int          drives_pending;
    // receiver hold-off requested by the stimulus
    logic        hold_results = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pi_lead_controller dut (.*);
    pi_lead_controller_check checker_i (.*);

    // random-length gap, mostly short, occasionally long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // result side: random stalls, plus a long hold-off when asked
    always @(posedge aclk) begin
        int wait_left;
        if (!aresetn) begin
            m_tready <= 1'b0;
            wait_left = 0;
        end else if (hold_results) begin
            m_tready <= 1'b0;
        end else if (wait_left > 0) begin
            m_tready <= 1'b0;
            wait_left--;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) wait_left = gap_len();
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // wait until every drive result is in, then let the block settle
    task automatic drain();
        while (drives_pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic send_request(input logic [30:0] dt, input logic [31:0] tgt,
                                input logic [31:0] meas, input logic frozen, input bit gaps);
        int idle;
        idle = gaps ? gap_len() : 0;
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, meas, tgt, dt};
        s_tuser <= frozen;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_input();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 8) << 16;
            3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_step();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 31'h7fffffff;
            2: return 31'($urandom);
            default: return 31'($urandom_range(1, 1 << 17));
        endcase
    endfunction

    task automatic setup(input logic [31:0] g, input logic [30:0] td, input logic [30:0] alpha,
                         input logic [30:0] ti, input logic fold);
        write_reg(REG_GAIN, g);
        write_reg(REG_LEAD_TIME, {1'b0, td});
        write_reg(REG_LEAD_RATIO, {1'b0, alpha});
        write_reg(REG_INTEGRAL_TIME, {1'b0, ti});
        write_reg(REG_FOLD_MODE, {31'b0, fold});
        write_reg(3'd7, $urandom);   // unmapped index, must be ignored
    endtask

    initial begin
        #100_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: defaults, zero step hold, field extremes
        send_request(31'h10000, 32'h00030000, 32'h00010000, 1'b0, 1'b0);
        send_request(31'h0, 32'h7fffffff, 32'h80000000, 1'b0, 1'b0);
        send_request(31'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b1, 1'b0);
        send_request(31'h1, 32'h80000000, 32'h7fffffff, 1'b0, 1'b0);
        idle_input();
        drain();
        // every stage on, fold on, integrator frozen and running
        setup(32'h00020000, 31'h4000, 31'h8000, 31'h10000, 1'b1);
        send_request(31'h400, 32'h00040000, 32'hfffc0000, 1'b0, 1'b0);
        send_request(31'h400, 32'h7fffffff, 32'h80000000, 1'b1, 1'b0);
        send_request(31'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        send_request(31'h400, 32'h00032440, 32'h0, 1'b0, 1'b0);
        send_request(31'h400, 32'hfffcdbc0, 32'h0, 1'b0, 1'b0);
        idle_input();
        drain();
        // extreme registers
        setup(32'h80000000, 31'h7fffffff, 31'h7fffffff, 31'h1, 1'b0);
        send_request(31'h7fffffff, 32'h12345678, 32'h87654321, 1'b0, 1'b0);
        send_request(31'h1, 32'hffffffff, 32'h1, 1'b0, 1'b0);
        idle_input();
        drain();
        setup(32'h7fffffff, 31'h1, 31'h0, 31'h7fffffff, 1'b1);
        send_request(31'h1, 32'h7fffffff, 32'h0, 1'b0, 1'b0);
        send_request(31'h7fffffff, 32'h80000000, 32'h0, 1'b0, 1'b0);

        // long receiver hold-off while requests keep coming
        hold_results <= 1'b1;
        fork
            repeat (8) send_request(rand_step(), rand_word(), rand_word(), 1'($urandom), 1'b0);
            begin
                repeat (3000) @(posedge aclk);
                hold_results <= 1'b0;
            end
        join
        idle_input();
        drain();

        // random phases, each with a new register setting
        for (int phase = 0; phase < 15; phase++) begin
            setup(rand_word(), $urandom_range(0, 2) == 0 ? 31'h0 : rand_step(),
                  rand_step(), $urandom_range(0, 2) == 0 ? 31'h0 : rand_step(), 1'($urandom));
            repeat (100) send_request(rand_step(), rand_word(), rand_word(),
                                      $urandom_range(0, 4) == 0, phase % 4 != 3);
            idle_input();
            drain();
        end

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
